FILE: hw/rtl/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// operation, mark and status codes shared by the edge table design
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int FUNC_W   = 3;
  localparam int MARK_W   = 2;
  localparam int WEIGHT_W = 16;
  localparam int DEG_W    = 7;
  localparam int STAT_W   = 2;
  localparam int PORT_NODE_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SETMARK = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEGREE  = 3'd4;

  localparam logic [MARK_W-1:0] MARK_ARROW = 2'd1;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

  localparam logic [DEG_W-1:0] DEG_MAX = 7'd127;

  typedef logic [MARK_W-1:0]   mark_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

FILE: hw/rtl/met_ram.sv
// ----------------------------------------------------------------------------
// met_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module met_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/marked_edge_table.sv
// ----------------------------------------------------------------------------
// marked_edge_table
// dense table of marked, weighted graph edges with add, remove, set marks,
// lookup and in-degree operations; one ram scanned by a shared comparator
// ----------------------------------------------------------------------------
//
//  channel  | ports                                         | dir | handshake
//  ---------+-----------------------------------------------+-----+----------
//  input    | in_func in_node_a in_node_b in_mark_a         | in  | in_valid /
//           | in_mark_b in_weight_in                        |     | in_ready
//  result   | out_found out_mark_a_out out_mark_b_out       | out | out_valid /
//           | out_weight_out out_degree out_status          |     | out_ready
//
//  a scan runs to the end of the table for a miss or an in-degree; a pair hit
//  stops it at the matching slot, and a remove that hits a slot other than the
//  last adds a move step that copies the last entry into the freed slot.
//  the scan reads one table entry per cycle through the single ram read port.
//  unused func codes skip the scan and go straight to the result step.
//  in_ready is high only while idle; a finished result waits in the output
//  register, and the sequencer holds its result until that register frees.
//  reset (synchronous, active low) empties the table; no clearing pass.
// ----------------------------------------------------------------------------
module marked_edge_table
  import met_pkg::*;
#(
  parameter int MAX_EDGES = 64,
  parameter int NODE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [PORT_NODE_W-1:0] in_node_a,
  input  logic [PORT_NODE_W-1:0] in_node_b,
  input  logic [MARK_W-1:0]      in_mark_a,
  input  logic [MARK_W-1:0]      in_mark_b,
  input  logic [WEIGHT_W-1:0]    in_weight_in,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [MARK_W-1:0]      out_mark_a_out,
  output logic [MARK_W-1:0]      out_mark_b_out,
  output logic [WEIGHT_W-1:0]    out_weight_out,
  output logic [DEG_W-1:0]       out_degree,
  output logic [STAT_W-1:0]      out_status
);

  // stored node width: the ports carry 8 bits, masked down to NODE_BITS
  localparam int SB = (NODE_BITS < PORT_NODE_W) ? NODE_BITS : PORT_NODE_W;
  localparam int AW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  // entry layout: {weight, second mark, first mark, second node, first node}
  localparam int EW    = 2 * SB + 2 * MARK_W + WEIGHT_W;
  localparam int S_LO  = SB;
  localparam int FM_LO = 2 * SB;
  localparam int SM_LO = 2 * SB + MARK_W;
  localparam int W_LO  = 2 * SB + 2 * MARK_W;

  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_EDGES);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  // operation payload
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [SB-1:0]     a_r, a_nxt;
  logic [SB-1:0]     b_r, b_nxt;
  mark_t             ma_r, ma_nxt;
  mark_t             mb_r, mb_nxt;
  weight_t           w_r, w_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [EW-1:0]     hit_r, hit_nxt;
  logic [DEG_W-1:0]  deg_r, deg_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  // result register
  logic              out_found_r, out_found_nxt;
  mark_t             out_ma_r, out_ma_nxt;
  mark_t             out_mb_r, out_mb_nxt;
  weight_t           out_w_r, out_w_nxt;
  logic [DEG_W-1:0]  out_deg_r, out_deg_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  // scan compare
  logic [SB-1:0] rd_first, rd_second;
  mark_t         rd_smark;
  logic          pair_hit, arrow_hit, issue_left, issue_go;
  logic [AW-1:0] last_idx;

  // hit entry fields
  logic [SB-1:0] hit_first, hit_second;
  mark_t         hit_fmark, hit_smark;
  weight_t       hit_w;
  logic          hit_direct;

  logic [EW-1:0] new_entry, mark_entry;

  met_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EDGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_first  = ram_rdata[SB-1:0];
  assign rd_second = ram_rdata[S_LO +: SB];
  assign rd_smark  = ram_rdata[SM_LO +: MARK_W];

  assign hit_first  = hit_r[SB-1:0];
  assign hit_second = hit_r[S_LO +: SB];
  assign hit_fmark  = hit_r[FM_LO +: MARK_W];
  assign hit_smark  = hit_r[SM_LO +: MARK_W];
  assign hit_w      = hit_r[W_LO +: WEIGHT_W];
  // query order matches stored order (covers self loops too)
  assign hit_direct = (a_r == hit_first);

  assign new_entry  = {w_r, mb_r, ma_r, b_r, a_r};
  assign mark_entry = hit_direct ? {hit_w, mb_r, ma_r, hit_second, hit_first}
                                 : {hit_w, ma_r, mb_r, hit_second, hit_first};

  // the shared comparator: one entry per cycle against the query
  assign pair_hit = pend_r && (func_r inside {[FUNC_ADD:FUNC_LOOKUP]}) &&
                    (((a_r == rd_first) && (b_r == rd_second)) ||
                     ((a_r == rd_second) && (b_r == rd_first)));
  assign arrow_hit = pend_r && (func_r == FUNC_DEGREE) &&
                     (rd_second == a_r) && (rd_smark == MARK_ARROW);

  assign issue_left = (issue_r < count_r);
  assign issue_go   = (state_r == S_SCAN) && issue_left && !pair_hit;
  assign last_idx   = AW'(count_r - 1'b1);

  // the act state reads the last entry for a remove that moves it
  assign ram_raddr = (state_r == S_ACT) ? last_idx : issue_r[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    func_nxt       = func_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    ma_nxt         = ma_r;
    mb_nxt         = mb_r;
    w_nxt          = w_r;
    pidx_nxt       = pidx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_nxt        = hit_r;
    deg_nxt        = deg_r;
    status_nxt     = status_r;
    out_found_nxt  = out_found_r;
    out_ma_nxt     = out_ma_r;
    out_mb_nxt     = out_mb_r;
    out_w_nxt      = out_w_r;
    out_deg_nxt    = out_deg_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = hit_idx_r;
    ram_wdata      = new_entry;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          a_nxt      = in_node_a[SB-1:0];
          b_nxt      = in_node_b[SB-1:0];
          ma_nxt     = in_mark_a;
          mb_nxt     = in_mark_b;
          w_nxt      = in_weight_in;
          issue_nxt  = '0;
          found_nxt  = 1'b0;
          deg_nxt    = '0;
          status_nxt = STAT_OK;
          // unused codes skip the scan and report all zeros
          state_nxt  = (in_func inside {[FUNC_ADD:FUNC_DEGREE]}) ? S_SCAN : S_FIN;
        end
      end

      S_SCAN: begin
        // issue the next read while checking the one that just returned
        pend_nxt = issue_go;
        pidx_nxt = issue_r[AW-1:0];
        if (issue_go) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (arrow_hit && (deg_r != DEG_MAX)) begin
          deg_nxt = deg_r + 1'b1;
        end
        if (pair_hit) begin
          found_nxt   = 1'b1;
          hit_idx_nxt = pidx_r;
          hit_nxt     = ram_rdata;
          state_nxt   = S_ACT;
        end else if (!pend_r && !issue_left) begin
          state_nxt = S_ACT;
        end
      end

      S_ACT: begin
        state_nxt = S_FIN;
        case (func_r)
          FUNC_ADD: begin
            if (found_r) begin
              ram_we = 1'b1;
            end else if (count_r == COUNT_FULL) begin
              status_nxt = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_r[AW-1:0];
              count_nxt = count_r + 1'b1;
            end
          end
          FUNC_REMOVE: begin
            if (found_r) begin
              if (hit_idx_r != last_idx) begin
                // last entry is being read; it lands in the freed slot next
                state_nxt = S_MOVE;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
          end
          FUNC_SETMARK: begin
            if (found_r) begin
              ram_we    = 1'b1;
              ram_wdata = mark_entry;
            end else begin
              status_nxt = STAT_MISSING;
            end
          end
          default: begin
          end
        endcase
      end

      S_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        count_nxt = count_r - 1'b1;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = found_r;
          out_deg_nxt    = deg_r;
          out_status_nxt = status_r;
          out_ma_nxt     = '0;
          out_mb_nxt     = '0;
          out_w_nxt      = '0;
          if ((func_r == FUNC_LOOKUP) && found_r) begin
            out_ma_nxt = hit_direct ? hit_fmark : hit_smark;
            out_mb_nxt = hit_direct ? hit_smark : hit_fmark;
            out_w_nxt  = hit_w;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    ma_r         <= ma_nxt;
    mb_r         <= mb_nxt;
    w_r          <= w_nxt;
    pidx_r       <= pidx_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_r        <= hit_nxt;
    deg_r        <= deg_nxt;
    status_r     <= status_nxt;
    out_found_r  <= out_found_nxt;
    out_ma_r     <= out_ma_nxt;
    out_mb_r     <= out_mb_nxt;
    out_w_r      <= out_w_nxt;
    out_deg_r    <= out_deg_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_mark_a_out = out_ma_r;
  assign out_mark_b_out = out_mb_r;
  assign out_weight_out = out_w_r;
  assign out_degree     = out_deg_r;
  assign out_status     = out_status_r;

  // table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("edge count above capacity");

  // the edge count only moves in the act or move steps
  a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) && $past(rst_n) |->
      ($past(state_r) == S_ACT) || ($past(state_r) == S_MOVE))
    else $error("edge count changed outside act/move");

  // a degree result never comes with a pair match
  a_deg_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_deg_r != '0) |-> !out_found_r)
    else $error("degree and found both set");

  // a full-table add is only flagged when the pair was absent
  a_full_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == STAT_FULL) |-> !out_found_r)
    else $error("full status on an existing edge");

endmodule
